FILE: sv/dec2i_pkg.sv
// Shared types and constants for the decimal text to int64 converter.
package dec2i_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned DigitW = 4;

  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  // Largest magnitudes: negative int64, positive int64, uint64.
  localparam logic [ValueW-1:0] LimNeg  = 64'h8000_0000_0000_0000;
  localparam logic [ValueW-1:0] LimPos  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValueW-1:0] LimUns  = 64'hFFFF_FFFF_FFFF_FFFF;

  // Quotient and remainder of each limit by ten, for the pre-multiply check.
  localparam logic [ValueW-1:0] QuotNeg = LimNeg / 64'd10;
  localparam logic [ValueW-1:0] QuotPos = LimPos / 64'd10;
  localparam logic [ValueW-1:0] QuotUns = LimUns / 64'd10;
  localparam logic [DigitW-1:0] RemNeg  = DigitW'(LimNeg % 64'd10);
  localparam logic [DigitW-1:0] RemPos  = DigitW'(LimPos % 64'd10);
  localparam logic [DigitW-1:0] RemUns  = DigitW'(LimUns % 64'd10);

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last_char;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              ok;
  } result_t;

endpackage

FILE: sv/dec2i_in_reg.sv
// Input register: captures one character transaction and holds it until consumed.
module dec2i_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  dec2i_pkg::item_t item_i,
  output logic            valid_o,
  output dec2i_pkg::item_t item_o,
  input  logic            advance_i
);
  import dec2i_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: sv/dec2i_core.sv
// Parse state and combinational step logic: accumulate digits, check range, form result.
module dec2i_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  dec2i_pkg::item_t   item_i,
  input  logic               signed_mode_i,
  output logic               res_valid_o,
  output dec2i_pkg::result_t res_o
);
  import dec2i_pkg::*;

  logic [ValueW-1:0] mag_q, mag_d;
  logic              neg_q, neg_d;
  logic              first_q, first_d;
  logic              failed_q, failed_d;

  logic              is_minus, is_digit, fits;
  logic [DigitW-1:0] digit;
  logic [ValueW-1:0] quot, mag_next, mag_eff;
  logic [DigitW-1:0] rem;
  logic              neg_eff, fail_eff;

  assign is_minus = first_q && signed_mode_i && (item_i.character == ChMinus);
  assign is_digit = (item_i.character >= ChZero) && (item_i.character <= ChNine);
  assign digit    = DigitW'(item_i.character - ChZero);

  always_comb begin
    priority if (neg_q) begin
      quot = QuotNeg;
      rem  = RemNeg;
    end else if (signed_mode_i) begin
      quot = QuotPos;
      rem  = RemPos;
    end else begin
      quot = QuotUns;
      rem  = RemUns;
    end
  end

  assign fits     = (mag_q < quot) || ((mag_q == quot) && (digit <= rem));
  // times ten as two shifts and an add
  assign mag_next = (mag_q << 3) + (mag_q << 1) + ValueW'(digit);

  always_comb begin
    mag_eff  = mag_q;
    neg_eff  = neg_q;
    fail_eff = failed_q;
    if (!failed_q) begin
      priority if (is_minus) begin
        neg_eff = 1'b1;
      end else if (is_digit && fits) begin
        mag_eff = mag_next;
      end else begin
        fail_eff = 1'b1;
      end
    end
  end

  always_comb begin
    mag_d    = mag_q;
    neg_d    = neg_q;
    first_d  = first_q;
    failed_d = failed_q;
    if (fire_i) begin
      if (item_i.last_char) begin
        // drop the string state once its result is out
        mag_d    = '0;
        neg_d    = 1'b0;
        first_d  = 1'b1;
        failed_d = 1'b0;
      end else begin
        mag_d    = mag_eff;
        neg_d    = neg_eff;
        first_d  = 1'b0;
        failed_d = fail_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q    <= '0;
      neg_q    <= 1'b0;
      first_q  <= 1'b1;
      failed_q <= 1'b0;
    end else begin
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      first_q  <= first_d;
      failed_q <= failed_d;
    end
  end

  assign res_valid_o = fire_i && item_i.last_char;
  always_comb begin
    res_o.ok    = !fail_eff;
    res_o.value = fail_eff ? '0 : (neg_eff ? ('0 - mag_eff) : mag_eff);
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last_char |=> first_q && !failed_q && !neg_q && (mag_q == '0))
    else $error("string state not cleared after last character");

  a_first_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.last_char |=> !first_q)
    else $error("first-character flag still set after a character");

  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && !(fire_i && item_i.last_char) |=> failed_q)
    else $error("error flag lost mid-string");

  a_failed_not_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> !first_q)
    else $error("error flag set before any character");

endmodule

FILE: sv/dec2i_out_reg.sv
// Output register: holds one result transaction until the receiver takes it.
module dec2i_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dec2i_pkg::result_t res_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               ready_i,
  output dec2i_pkg::result_t res_o
);
  import dec2i_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> space_o)
    else $error("result loaded while previous one still held");

  a_failed_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.ok |-> (res_q.value == '0))
    else $error("failed result carries a nonzero value");

endmodule

FILE: sv/decimal_text_to_int64_checked_top.sv
// Top level of the checked ASCII decimal to 64-bit integer converter.
//
// Input channel (in_valid_i / in_ready_o): one ASCII character per transaction,
// with last_char_i marking the final character of a string. Output channel
// (out_valid_o / out_ready_i): one result per string, value_o and ok_o; a
// failed string gives value 0 with ok 0. Config channel (cfg_valid_i /
// cfg_ready_o): writes signed_mode, always ready; write only while idle.
//
// Throughput: one character per cycle, but a last character waits while the
// result slot is taken. Its result is formed in the step stage and registered
// in the output register. The timing path is the times-ten multiply-add of
// the 64-bit magnitude followed by the negate in the single step stage.
//
// Reset clears the string state, sets signed_mode to 1 and empties both
// registers. When the receiver stalls, the output register holds its result;
// characters that are not last keep flowing, and a last character waits in
// the input register until the result slot frees, which then backs up the
// input channel.
module decimal_text_to_int64_checked_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic        ok_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_signed_mode_i
);
  import dec2i_pkg::*;

  logic    signed_mode_q;
  item_t   in_item, s1_item;
  logic    s1_valid, advance, space;
  logic    res_valid;
  result_t res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      signed_mode_q <= cfg_signed_mode_i;
    end
  end

  assign in_item.character = character_i;
  assign in_item.last_char = last_char_i;

  // advance unless a last character finds the result slot taken
  assign advance = s1_valid && (!s1_item.last_char || space);

  dec2i_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .item_i    (in_item),
    .valid_o   (s1_valid),
    .item_o    (s1_item),
    .advance_i (advance)
  );

  dec2i_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (advance),
    .item_i        (s1_item),
    .signed_mode_i (signed_mode_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  dec2i_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign value_o = out_res.value;
  assign ok_o    = out_res.ok;

endmodule
